// ===== rtl/core/dsv_pkg.sv =====
package dsv_pkg;

  localparam int unsigned CHAR_W    = 8;
  localparam int unsigned POS_W     = 4;
  localparam int unsigned YEAR_W    = 14;
  localparam int unsigned MONTH_W   = 7;
  localparam int unsigned DAY_W     = 7;
  localparam int unsigned MOD25_W   = 5;
  localparam int unsigned DIGIT_W   = 4;
  localparam int unsigned DIM_W     = 5;
  localparam int unsigned VERDICT_W = 3;

  localparam logic [YEAR_W-1:0]  YEAR_MIN       = 14'd2009;
  localparam logic [YEAR_W-1:0]  CUR_YEAR_RESET = 14'd2025;

  localparam logic [POS_W-1:0]   POS_DASH_MONTH = 4'd4;
  localparam logic [POS_W-1:0]   POS_DASH_DAY   = 4'd7;
  localparam logic [POS_W-1:0]   DATE_LEN       = 4'd10;
  localparam logic [POS_W-1:0]   POS_SAT        = 4'd11;

  localparam logic [CHAR_W-1:0]  CHAR_DASH = 8'h2D;
  localparam logic [CHAR_W-1:0]  CHAR_ZERO = 8'h30;
  localparam logic [CHAR_W-1:0]  CHAR_NINE = 8'h39;

  localparam logic [MONTH_W-1:0] MONTH_MIN = 7'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 7'd2;
  localparam logic [MONTH_W-1:0] MONTH_APR = 7'd4;
  localparam logic [MONTH_W-1:0] MONTH_JUN = 7'd6;
  localparam logic [MONTH_W-1:0] MONTH_SEP = 7'd9;
  localparam logic [MONTH_W-1:0] MONTH_NOV = 7'd11;
  localparam logic [MONTH_W-1:0] MONTH_MAX = 7'd12;

  localparam logic [DAY_W-1:0]   DAY_MIN   = 7'd1;
  localparam logic [DAY_W-1:0]   DAY_LIMIT = 7'd31;

  localparam logic [DIM_W-1:0]   DIM_SHORT = 5'd30;
  localparam logic [DIM_W-1:0]   DIM_LONG  = 5'd31;
  localparam logic [DIM_W-1:0]   DIM_FEB   = 5'd28;
  localparam logic [DIM_W-1:0]   DIM_LEAP  = 5'd29;

  typedef enum logic [VERDICT_W-1:0] {
    VERDICT_OK       = 3'd0,
    VERDICT_LENGTH   = 3'd1,
    VERDICT_DASH     = 3'd2,
    VERDICT_NONDIGIT = 3'd3,
    VERDICT_YEAR     = 3'd4,
    VERDICT_MONTH    = 3'd5,
    VERDICT_DAY      = 3'd6
  } verdict_t;

  typedef struct packed {
    logic [POS_W-1:0]   pos;
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic [MOD25_W-1:0] year_mod25;
    logic               dash_bad;
    logic               digit_bad;
  } scan_t;

  // (r * 10 + d) mod 25, quotient by reciprocal 41 / 1024, exact below 256
  function automatic logic [MOD25_W-1:0] mod25_step(logic [MOD25_W-1:0] r,
                                                     logic [DIGIT_W-1:0] d);
    logic [7:0]  v;
    logic [13:0] p;
    logic [3:0]  q;
    logic [7:0]  qm;
    logic [7:0]  rem;
    v   = {r, 3'b000} + {2'b00, r, 1'b0} + {4'b0000, d};
    p   = {6'b000000, v} * 14'd41;
    q   = p[13:10];
    qm  = {4'b0000, q} * 8'd25;
    rem = v - qm;
    return rem[MOD25_W-1:0];
  endfunction

  function automatic logic [DIM_W-1:0] month_days(logic [MONTH_W-1:0] m, logic leap);
    logic [DIM_W-1:0] dim;
    dim = DIM_LONG;
    if (m == MONTH_APR || m == MONTH_JUN || m == MONTH_SEP || m == MONTH_NOV) begin
      dim = DIM_SHORT;
    end else if (m == MONTH_FEB) begin
      dim = leap ? DIM_LEAP : DIM_FEB;
    end
    return dim;
  endfunction

endpackage

// ===== rtl/core/dsv_scan.sv =====
module dsv_scan import dsv_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [CHAR_W-1:0] char_code,
  input  logic              last_char,
  output logic              fin_valid,
  input  logic              fin_ready,
  output scan_t             fin
);

  logic              s1_valid;
  logic [CHAR_W-1:0] s1_char;
  logic              s1_last;
  logic              s1_take;
  logic              fin_free;
  scan_t             st;
  scan_t             st_next;
  logic [CHAR_W-1:0] char_off;
  logic [DIGIT_W-1:0] digit;
  logic              is_digit;

  assign fin_free = !fin_valid || fin_ready;
  assign s1_take  = s1_valid && (!s1_last || fin_free);
  assign in_ready = !s1_valid || s1_take;

  assign char_off = s1_char - CHAR_ZERO;
  assign digit    = char_off[DIGIT_W-1:0];
  assign is_digit = (s1_char >= CHAR_ZERO) && (s1_char <= CHAR_NINE);

  always_comb begin
    st_next = st;
    if (st.pos == POS_DASH_MONTH || st.pos == POS_DASH_DAY) begin
      if (s1_char != CHAR_DASH) begin
        st_next.dash_bad = 1'b1;
      end
    end else if (st.pos < DATE_LEN) begin
      if (!is_digit) begin
        st_next.digit_bad = 1'b1;
      end else if (st.pos < POS_DASH_MONTH) begin
        st_next.year = {st.year[YEAR_W-4:0], 3'b000} + {st.year[YEAR_W-2:0], 1'b0}
                       + {{(YEAR_W-DIGIT_W){1'b0}}, digit};
        st_next.year_mod25 = mod25_step(st.year_mod25, digit);
      end else if (st.pos < POS_DASH_DAY) begin
        st_next.month = {st.month[MONTH_W-4:0], 3'b000} + {st.month[MONTH_W-2:0], 1'b0}
                        + {{(MONTH_W-DIGIT_W){1'b0}}, digit};
      end else begin
        st_next.day = {st.day[DAY_W-4:0], 3'b000} + {st.day[DAY_W-2:0], 1'b0}
                      + {{(DAY_W-DIGIT_W){1'b0}}, digit};
      end
    end
    if (st.pos < POS_SAT) begin
      st_next.pos = st.pos + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      fin_valid <= 1'b0;
      st        <= '0;
    end else begin
      if (in_ready) begin
        s1_valid <= in_valid;
      end
      if (s1_take && s1_last) begin
        fin_valid <= 1'b1;
      end else if (fin_ready) begin
        fin_valid <= 1'b0;
      end
      if (s1_take) begin
        if (s1_last) begin
          st <= '0;
        end else begin
          st <= st_next;
        end
      end
    end
  end

  // hold the item payload and the finished record
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_char <= char_code;
      s1_last <= last_char;
    end
    if (s1_take && s1_last) begin
      fin <= st_next;
    end
  end

endmodule

// ===== rtl/core/dsv_judge.sv =====
module dsv_judge import dsv_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 fin_valid,
  output logic                 fin_ready,
  input  scan_t                fin,
  input  logic [YEAR_W-1:0]    current_year,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [VERDICT_W-1:0] verdict_code,
  output logic [YEAR_W-1:0]    year_value,
  output logic [MONTH_W-1:0]   month_value,
  output logic [DAY_W-1:0]     day_value
);

  verdict_t         verdict;
  logic             leap;
  logic             mod25_zero;
  logic [DIM_W-1:0] dim;

  assign fin_ready  = !out_valid || out_ready;
  assign mod25_zero = (fin.year_mod25 == '0);
  assign leap       = ((fin.year[1:0] == 2'b00) && !mod25_zero)
                   || ((fin.year[3:0] == 4'b0000) && mod25_zero);
  assign dim        = month_days(fin.month, leap);

  always_comb begin
    priority if (fin.pos != DATE_LEN) begin
      verdict = VERDICT_LENGTH;
    end else if (fin.dash_bad) begin
      verdict = VERDICT_DASH;
    end else if (fin.digit_bad) begin
      verdict = VERDICT_NONDIGIT;
    end else if (fin.year < YEAR_MIN || fin.year > current_year) begin
      verdict = VERDICT_YEAR;
    end else if (fin.month < MONTH_MIN || fin.month > MONTH_MAX) begin
      verdict = VERDICT_MONTH;
    end else if (fin.day < DAY_MIN || fin.day > {2'b00, dim}) begin
      verdict = VERDICT_DAY;
    end else begin
      verdict = VERDICT_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fin_ready) begin
      out_valid <= fin_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_ready && fin_valid) begin
      verdict_code <= verdict;
      year_value   <= fin.year;
      month_value  <= fin.month;
      day_value    <= fin.day;
    end
  end

endmodule

// ===== rtl/core/date_string_validator_unit.sv =====
// Checks an ASCII date of the form YYYY-MM-DD sent one character per item, with
// last_char set on the final character, and returns one verdict item per string
// (0 ok, 1 length, 2 dash, 3 non-digit, 4 year, 5 month, 6 day, first failing
// check wins) together with the parsed year, month and day. A character is
// taken every cycle unless a last character waits on a full finished-record
// register. The character is registered at acceptance, the accumulator update
// loads the finished record from it, then the range and calendar checks load
// the output register. The accumulator update of one character per cycle
// sets the rate while no last character waits. current_year (reset 2025)
// bounds the accepted years from above; the user must write it through
// cfg_write_en / cfg_write_data only while no string is in flight; not enforced.
module date_string_validator_unit import dsv_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write_en,
  input  logic [YEAR_W-1:0]    cfg_write_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [CHAR_W-1:0]    char_code,
  input  logic                 last_char,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [VERDICT_W-1:0] verdict_code,
  output logic [YEAR_W-1:0]    year_value,
  output logic [MONTH_W-1:0]   month_value,
  output logic [DAY_W-1:0]     day_value
);

  logic [YEAR_W-1:0] current_year;
  logic              fin_valid;
  logic              fin_ready;
  scan_t             fin;

  always_ff @(posedge clk) begin
    if (rst) begin
      current_year <= CUR_YEAR_RESET;
    end else if (cfg_write_en) begin
      current_year <= cfg_write_data;
    end
  end

  dsv_scan u_scan (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .char_code (char_code),
    .last_char (last_char),
    .fin_valid (fin_valid),
    .fin_ready (fin_ready),
    .fin       (fin)
  );

  dsv_judge u_judge (
    .clk          (clk),
    .rst          (rst),
    .fin_valid    (fin_valid),
    .fin_ready    (fin_ready),
    .fin          (fin),
    .current_year (current_year),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .verdict_code (verdict_code),
    .year_value   (year_value),
    .month_value  (month_value),
    .day_value    (day_value)
  );

`ifndef SYNTHESIS
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output register");

  a_ok_fields: assert property (@(posedge clk) disable iff (rst)
    (out_valid && verdict_code == VERDICT_OK) |->
      (year_value >= YEAR_MIN && month_value >= MONTH_MIN && month_value <= MONTH_MAX
       && day_value >= DAY_MIN && day_value <= DAY_LIMIT))
    else $error("ok verdict with out-of-range fields");

  a_no_result_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result item present straight after reset");

  a_verdict_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (verdict_code <= VERDICT_DAY))
    else $error("verdict code out of range");
`endif

endmodule
